[rtl/c3lp_pkg.sv]
// Shared types, codes and coefficient tables for the third-order
// inverse-Chebyshev lowpass. No dependencies.
package c3lp_pkg;

  // Coefficient word: signed, at most 30 fraction bits
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned Q30_FRAC  = 30;

  // Stopband selector codes
  localparam logic [1:0] SEL_27DB = 2'd0;
  localparam logic [1:0] SEL_25DB = 2'd1;
  localparam logic [1:0] SEL_23DB = 2'd2;

  // Rows: 27 dB, 25 dB, 23 dB; columns: b0, b1, a1, a2, a1f in Q30
  localparam longint COEF_Q30 [3][5] = '{
    '{64'sd11725100, -64'sd22962967, -64'sd2050886269, 64'sd986605914, -64'sd963155725},
    '{64'sd14663051, -64'sd28716785, -64'sd2045395528, 64'sd982506969, -64'sd953180868},
    '{64'sd18333970, -64'sd35906098, -64'sd2040015309, 64'sd978694692, -64'sd942026741}
  };

  // Feedback coefficients are kept negated so every product is added
  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_NA1,
    COEF_NA2,
    COEF_NA1F
  } coef_e;

  typedef enum logic [2:0] {
    SRC_X,
    SRC_Y_LO,
    SRC_Y_HI,
    SRC_Z_LO,
    SRC_Z_HI
  } src_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_Y,
    ADD_D1_LOAD,
    ADD_Z,
    ADD_D1_T,
    ADD_D1_D2,
    ADD_D2,
    ADD_FD
  } add_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  // One step of the per-sample schedule
  typedef enum logic [3:0] {
    S_MUL_B0X,
    S_MUL_B1X,
    S_ROUND_B0X,
    S_ADD_Y,
    S_MUL_A1_LO,
    S_MUL_A1_HI,
    S_MUL_A2_LO,
    S_MUL_A2_HI,
    S_MUL_A1F_LO,
    S_MUL_A1F_HI,
    S_ACC_A1F,
    S_ROUND_A1F,
    S_WRITE_FD
  } sched_e;

  typedef struct packed {
    logic    load_x;
    coef_e   mul_coef;
    src_e    mul_src;
    acc_op_e acc_op;
    logic    rnd_frac;
    add_op_e add_op;
    logic    out_load;
  } dp_cmd_t;

  // Coefficient at the given fraction width, rounded half away from zero
  function automatic logic signed [COEF_W-1:0] coef_value(logic [1:0] sel, coef_e idx,
                                                          int unsigned frac);
    longint      q;
    longint      mag;
    longint      half;
    longint      r;
    int unsigned sh;
    int unsigned row;
    logic        neg;
    row  = (sel == SEL_27DB) ? 0 : ((sel == SEL_25DB) ? 1 : 2);
    q    = COEF_Q30[row][idx];
    sh   = Q30_FRAC - frac;
    half = (sh > 0) ? (longint'(1) <<< (sh - 1)) : longint'(0);
    mag  = (q < 0) ? -q : q;
    r    = (mag + half) >>> sh;
    neg  = (q < 0) ^ ((idx == COEF_NA1) || (idx == COEF_NA2) || (idx == COEF_NA1F));
    if (neg) begin
      r = -r;
    end
    return COEF_W'(r);
  endfunction

endpackage

[rtl/c3lp_ctrl.sv]
// Sequencer for the lowpass: walks the thirteen-step schedule per sample
// and drives the datapath commands. Depends on c3lp_pkg.
module c3lp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output c3lp_pkg::dp_cmd_t  cmd_o
);
  import c3lp_pkg::*;

  ctrl_state_e state_q, state_d;
  sched_e      step_q, step_d;
  logic        m_valid_q, m_valid_d;
  logic        out_free;
  dp_cmd_t     cmd;

  assign out_free   = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= S_MUL_B0X;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cmd.load_x    = 1'b0;
    cmd.mul_coef  = COEF_B0;
    cmd.mul_src   = SRC_X;
    cmd.acc_op    = ACC_HOLD;
    cmd.rnd_frac  = 1'b1;
    cmd.add_op    = ADD_NONE;
    cmd.out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd.load_x = 1'b1;
          state_d    = ST_RUN;
          step_d     = S_MUL_B0X;
        end
      end
      ST_RUN: begin
        unique case (step_q)
          S_MUL_B0X: begin
            cmd.mul_coef = COEF_B0;
            cmd.mul_src  = SRC_X;
          end
          S_MUL_B1X: begin
            cmd.mul_coef = COEF_B1;
            cmd.mul_src  = SRC_X;
            cmd.acc_op   = ACC_LOAD;
          end
          S_ROUND_B0X: begin
            cmd.acc_op   = ACC_LOAD;
            cmd.rnd_frac = 1'b0;
          end
          S_ADD_Y: begin
            cmd.rnd_frac = 1'b0;
            cmd.add_op   = ADD_Y;
          end
          S_MUL_A1_LO: begin
            cmd.mul_coef = COEF_NA1;
            cmd.mul_src  = SRC_Y_LO;
            cmd.add_op   = ADD_D1_LOAD;
          end
          S_MUL_A1_HI: begin
            cmd.mul_coef = COEF_NA1;
            cmd.mul_src  = SRC_Y_HI;
            cmd.acc_op   = ACC_LOAD;
            cmd.add_op   = ADD_Z;
          end
          S_MUL_A2_LO: begin
            cmd.mul_coef = COEF_NA2;
            cmd.mul_src  = SRC_Y_LO;
            cmd.acc_op   = ACC_ADD_HI;
          end
          S_MUL_A2_HI: begin
            cmd.mul_coef = COEF_NA2;
            cmd.mul_src  = SRC_Y_HI;
            cmd.acc_op   = ACC_LOAD;
          end
          S_MUL_A1F_LO: begin
            cmd.mul_coef = COEF_NA1F;
            cmd.mul_src  = SRC_Z_LO;
            cmd.acc_op   = ACC_ADD_HI;
            cmd.add_op   = ADD_D1_T;
          end
          S_MUL_A1F_HI: begin
            cmd.mul_coef = COEF_NA1F;
            cmd.mul_src  = SRC_Z_HI;
            cmd.acc_op   = ACC_LOAD;
            cmd.add_op   = ADD_D1_D2;
          end
          S_ACC_A1F: begin
            cmd.acc_op = ACC_ADD_HI;
            cmd.add_op = ADD_D2;
          end
          S_ROUND_A1F: begin
          end
          S_WRITE_FD: begin
            // hold here until the output register is free
            if (out_free) begin
              cmd.add_op   = ADD_FD;
              cmd.out_load = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (step_q == S_WRITE_FD) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          step_d = sched_e'(step_q + 4'd1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

endmodule

[rtl/c3lp_datapath.sv]
// Datapath for the lowpass: shared multiplier, product accumulator,
// round/saturate stage, saturating adder and the filter states. Uses c3lp_pkg.
module c3lp_datapath #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned COEF_FRAC_BITS = 28,
  parameter int unsigned STATE_WIDTH    = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  c3lp_pkg::dp_cmd_t       cmd_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_data_i,
  output logic [SAMPLE_WIDTH-1:0] sample_out_o
);
  import c3lp_pkg::*;

  localparam int unsigned SW = STATE_WIDTH;
  localparam int unsigned CF = COEF_FRAC_BITS;
  localparam int unsigned LW = SW / 2;
  localparam int unsigned OW = (SAMPLE_WIDTH > LW + 1) ? SAMPLE_WIDTH : LW + 1;
  localparam int unsigned PW = COEF_W + OW;
  localparam int unsigned AW = COEF_W + SW;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] O_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] O_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [AW:0] A_HALF    = {{(AW+1-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [AW:0] A_HALF_M1 = A_HALF - 1'b1;
  localparam logic signed [SW:0] Z_HALF    = {{(SW+1-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [SW:0] Z_HALF_M1 = Z_HALF - 1'b1;

  logic [1:0]                     sel_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SW-1:0]           d1_q, d2_q, fd_q;
  logic signed [SW-1:0]           y_q, z_q, bx0_q;
  logic signed [PW-1:0]           prod_q, prod_d;
  logic signed [AW-1:0]           acc_q, acc_d;
  logic signed [SW-1:0]           term_q, term_d;
  logic [SAMPLE_WIDTH-1:0]        out_q, out_d;

  logic signed [COEF_W-1:0]       coef_s;
  logic signed [OW-1:0]           opnd_s;
  logic signed [AW:0]             acc_x, rnd_sum, rnd_shift;
  logic signed [SW-1:0]           add_a, add_b, add_sat;
  logic signed [SW:0]             add_sum;
  logic signed [SW:0]             z_x, z_sum, z_shift;

  // Multiplier: one coefficient times x or one half of a state
  assign coef_s = coef_value(sel_q, cmd_i.mul_coef, CF);

  always_comb begin
    unique case (cmd_i.mul_src)
      SRC_X:    opnd_s = OW'(x_q);
      SRC_Y_LO: opnd_s = OW'({1'b0, y_q[LW-1:0]});
      SRC_Y_HI: opnd_s = OW'($signed(y_q[SW-1:LW]));
      SRC_Z_LO: opnd_s = OW'({1'b0, z_q[LW-1:0]});
      SRC_Z_HI: opnd_s = OW'($signed(z_q[SW-1:LW]));
      default:  opnd_s = OW'(x_q);
    endcase
  end

  assign prod_d = coef_s * opnd_s;

  // Accumulate low and shifted high partial products into the exact product
  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_HOLD:   acc_d = acc_q;
      ACC_LOAD:   acc_d = AW'(prod_q);
      ACC_ADD_HI: acc_d = acc_q + (AW'(prod_q) <<< LW);
      default:    acc_d = acc_q;
    endcase
  end

  // Round half away from zero when rnd_frac is set, then saturate to the state range
  always_comb begin
    acc_x = (AW+1)'(acc_q);
    if (cmd_i.rnd_frac) begin
      rnd_sum   = acc_x + (acc_q[AW-1] ? A_HALF_M1 : A_HALF);
      rnd_shift = rnd_sum >>> CF;
    end else begin
      rnd_sum   = acc_x;
      rnd_shift = acc_x;
    end
    if ((&rnd_shift[AW:SW-1]) || !(|rnd_shift[AW:SW-1])) begin
      term_d = rnd_shift[SW-1:0];
    end else begin
      term_d = rnd_shift[AW] ? S_MIN : S_MAX;
    end
  end

  // Saturating adder shared by all state updates
  always_comb begin
    unique case (cmd_i.add_op)
      ADD_Y: begin
        add_a = term_q;
        add_b = d1_q;
      end
      ADD_D1_LOAD: begin
        add_a = term_q;
        add_b = '0;
      end
      ADD_Z: begin
        add_a = y_q;
        add_b = fd_q;
      end
      ADD_D1_T: begin
        add_a = d1_q;
        add_b = term_q;
      end
      ADD_D1_D2: begin
        add_a = d1_q;
        add_b = d2_q;
      end
      ADD_D2: begin
        add_a = bx0_q;
        add_b = term_q;
      end
      ADD_FD: begin
        add_a = y_q;
        add_b = term_q;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
    add_sum = (SW+1)'(add_a) + (SW+1)'(add_b);
    if (add_sum[SW] != add_sum[SW-1]) begin
      add_sat = add_sum[SW] ? S_MIN : S_MAX;
    end else begin
      add_sat = add_sum[SW-1:0];
    end
  end

  // Output sample: z rounded to an integer and saturated
  always_comb begin
    z_x     = (SW+1)'(z_q);
    z_sum   = z_x + (z_q[SW-1] ? Z_HALF_M1 : Z_HALF);
    z_shift = z_sum >>> CF;
    if ((&z_shift[SW:SAMPLE_WIDTH-1]) || !(|z_shift[SW:SAMPLE_WIDTH-1])) begin
      out_d = z_shift[SAMPLE_WIDTH-1:0];
    end else begin
      out_d = z_shift[SW] ? O_MIN : O_MAX;
    end
  end

  // Filter states and selector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_23DB;
      d1_q  <= '0;
      d2_q  <= '0;
      fd_q  <= '0;
    end else if (cfg_we_i) begin
      sel_q <= (cfg_data_i == SEL_27DB || cfg_data_i == SEL_25DB) ? cfg_data_i : SEL_23DB;
      d1_q  <= '0;
      d2_q  <= '0;
      fd_q  <= '0;
    end else begin
      unique case (cmd_i.add_op)
        ADD_D1_LOAD, ADD_D1_T, ADD_D1_D2: d1_q <= add_sat;
        ADD_D2:                           d2_q <= add_sat;
        ADD_FD:                           fd_q <= add_sat;
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    term_q <= term_d;
    if (cmd_i.load_x) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.add_op == ADD_Y) begin
      y_q   <= add_sat;
      bx0_q <= term_q;
    end
    if (cmd_i.add_op == ADD_Z) begin
      z_q <= add_sat;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign sample_out_o = out_q;

endmodule

[rtl/cheby3_lowpass_iir_top.sv]
// A new sample is accepted only while idle, after the last result is written;
// the single shared multiplier works through eight products per sample
// on a fixed schedule.
// A result waiting in the output register stalls only the last step.
// Reset (rst_ni low, asynchronous): all three filter states cleared,
// 23 dB coefficient set selected. A configuration write also clears states.
module cheby3_lowpass_iir_top #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned COEF_FRAC_BITS = 28,
  parameter int unsigned STATE_WIDTH    = 48,
  localparam int unsigned TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: stopband_select
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,   // [SAMPLE_WIDTH-1:0] sample_in
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o    // [SAMPLE_WIDTH-1:0] sample_out
);
  import c3lp_pkg::*;

  dp_cmd_t                 cmd;
  logic [SAMPLE_WIDTH-1:0] sample_out;

  assign cfg_ready_o = 1'b1;

  c3lp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  c3lp_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_in_i  (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .sample_out_o (sample_out)
  );

  // zero-pad the sample up to whole bytes
  assign m_axis_tdata_o = TDATA_W'(sample_out);

endmodule
